@@ rtl/tsrc_pkg.sv @@
// Package with item types, codes and constants for the TCP segment receive checker.
`default_nettype none
package tsrc_pkg;
    localparam int Entries = 8;
    localparam int IdxW = 3;

    localparam logic [1:0] OP_WORD    = 2'd0;
    localparam logic [1:0] OP_OPEN    = 2'd1;
    localparam logic [1:0] OP_FINWAIT = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    localparam logic [2:0] ST_SYN_SENT    = 3'd0;
    localparam logic [2:0] ST_ESTABLISHED = 3'd1;
    localparam logic [2:0] ST_FIN_WAIT_1  = 3'd2;
    localparam logic [2:0] ST_FIN_WAIT_2  = 3'd3;
    localparam logic [2:0] ST_CLOSED      = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_BADCS = 2'd1;
    localparam logic [1:0] STAT_NOCON = 2'd2;

    localparam logic [7:0] FLAG_ACK = 8'h10;
    localparam logic [7:0] FLAG_SYN = 8'h02;
    localparam logic [7:0] FLAG_FIN = 8'h01;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  entry_index;
        logic [31:0] remote_addr;
        logic [31:0] local_addr;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] seq_value;
        logic [31:0] ack_value;
        logic [15:0] data_word;
        logic [1:0]  last_byte_count;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        ack_mismatch;
        logic        send_ack;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [2:0]  matched_entry;
        logic [2:0]  new_state;
    } out_item_t;

    function automatic logic [15:0] fold16(input logic [19:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction
endpackage
`default_nettype wire

@@ rtl/tcp_segment_receive_checker_top.sv @@
// Top level of the TCP segment receive checker: table, checksum and state update.
// A result is registered and appears in the cycle after the last word of a segment is taken.
// Throughput: one item per cycle; busy is always low and results cannot be stalled.
// The work for an item is done between the item's capture and the result register.
// Reset clears all entry valid bits, the running sum, word count and parsed header.
`default_nettype none
module tcp_segment_receive_checker_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire tsrc_pkg::in_item_t   in_item,
    output logic                      strobe,
    output tsrc_pkg::out_item_t       out_item
);
    import tsrc_pkg::*;

    logic [Entries-1:0] valid_reg;
    logic [31:0] raddr_reg [Entries];
    logic [31:0] laddr_reg [Entries];
    logic [31:0] ports_reg [Entries];
    logic [2:0]  cstate_reg [Entries];
    logic [31:0] seq_reg [Entries];
    logic [31:0] ack_reg [Entries];

    logic [15:0] sum_reg, sum_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [63:0] hdr0_reg, hdr0_next, hdr1_reg, hdr1_next;
    logic        strobe_reg;
    out_item_t   out_reg, out_next;

    logic        take, seg, last, odd, csok, hit;
    logic [15:0] word, len, fsum;
    logic [19:0] psum;
    logic [IdxW-1:0] hidx;
    logic [15:0] sport, dport;
    logic [31:0] sseq, sack, nseq, nack;
    logic [7:0]  flags;
    logic [2:0]  st, nst;
    logic        upd, sendack;

    assign busy = 1'b0;
    assign take = start;
    assign seg  = take && in_item.operation == OP_WORD;
    assign last = in_item.last_word;
    assign odd  = last && in_item.last_byte_count == 2'd1;
    assign word = odd ? {in_item.data_word[15:8], 8'h00} : in_item.data_word;

    always_comb
    begin
        hdr0_next = hdr0_reg;
        hdr1_next = hdr1_reg;
        case (cnt_reg)
            16'd0: hdr0_next[63:48] = word;
            16'd1: hdr0_next[47:32] = word;
            16'd2: hdr0_next[31:16] = word;
            16'd3: hdr0_next[15:0]  = word;
            16'd4: hdr1_next[63:48] = word;
            16'd5: hdr1_next[47:32] = word;
            16'd6: hdr1_next[7:0]   = word[7:0];
            default: ;
        endcase
        sum_next = fold16({4'd0, sum_reg} + {4'd0, word});
        cnt_next = (cnt_reg == 16'hffff) ? cnt_reg : cnt_reg + 16'd1;
    end

    assign len  = {cnt_next[14:0], 1'b0} - {15'd0, odd};
    assign psum = {4'd0, sum_next} + {4'd0, in_item.remote_addr[31:16]}
                + {4'd0, in_item.remote_addr[15:0]} + {4'd0, in_item.local_addr[31:16]}
                + {4'd0, in_item.local_addr[15:0]} + 20'd6 + {4'd0, len};
    assign fsum = fold16(psum);
    assign csok = fsum == 16'hffff;

    assign sport = hdr0_next[63:48];
    assign dport = hdr0_next[47:32];
    assign sseq  = hdr0_next[31:0];
    assign sack  = hdr1_next[63:32];
    assign flags = hdr1_next[7:0];

    always_comb
    begin
        hit = 1'b0;
        hidx = '0;
        for (int i = Entries - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && raddr_reg[i] == in_item.remote_addr
                && laddr_reg[i] == in_item.local_addr
                && ports_reg[i] == {dport, sport})
            begin
                hit = 1'b1;
                hidx = IdxW'(i);
            end
        end
    end

    always_comb
    begin
        st = cstate_reg[hidx];
        nst = st;
        nseq = seq_reg[hidx];
        nack = ack_reg[hidx];
        upd = 1'b0;
        sendack = 1'b0;
        if (st == ST_SYN_SENT && (flags & FLAG_ACK) != 0 && (flags & FLAG_SYN) != 0)
        begin
            nst = ST_ESTABLISHED; nseq = sack; nack = sseq + 32'd1;
            upd = 1'b1; sendack = 1'b1;
        end
        else if (st == ST_FIN_WAIT_1 && (flags & FLAG_ACK) != 0)
        begin
            nst = ST_FIN_WAIT_2; upd = 1'b1;
        end
        else if (st == ST_FIN_WAIT_2 && (flags & FLAG_FIN) != 0)
        begin
            nst = ST_CLOSED; nseq = sack; nack = sseq + 32'd1;
            upd = 1'b1; sendack = 1'b1;
        end
        out_next = '0;
        if (!csok)
            out_next.status = STAT_BADCS;
        else if (!hit)
            out_next.status = STAT_NOCON;
        else
        begin
            out_next.status = STAT_OK;
            out_next.ack_mismatch = sack != seq_reg[hidx] + 32'd1;
            out_next.send_ack = sendack;
            out_next.reply_seq = nseq;
            out_next.reply_ack = nack;
            out_next.matched_entry = hidx;
            out_next.new_state = nst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            hdr0_reg   <= '0;
            hdr1_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= seg && last;
            if (seg)
            begin
                if (last)
                begin
                    sum_reg <= '0; cnt_reg <= '0; hdr0_reg <= '0; hdr1_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next; cnt_reg <= cnt_next;
                    hdr0_reg <= hdr0_next; hdr1_reg <= hdr1_next;
                end
            end
            if (take && in_item.operation == OP_OPEN)
                valid_reg[in_item.entry_index] <= 1'b1;
            if (take && in_item.operation == OP_RELEASE)
                valid_reg[in_item.entry_index] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (take && in_item.operation == OP_OPEN)
        begin
            raddr_reg[in_item.entry_index]  <= in_item.remote_addr;
            laddr_reg[in_item.entry_index]  <= in_item.local_addr;
            ports_reg[in_item.entry_index]  <= {in_item.local_port, in_item.remote_port};
            cstate_reg[in_item.entry_index] <= ST_SYN_SENT;
            seq_reg[in_item.entry_index]    <= in_item.seq_value;
            ack_reg[in_item.entry_index]    <= in_item.ack_value;
        end
        else if (take && in_item.operation == OP_FINWAIT && valid_reg[in_item.entry_index])
            cstate_reg[in_item.entry_index] <= ST_FIN_WAIT_1;
        else if (seg && last && csok && hit && upd)
        begin
            cstate_reg[hidx] <= nst;
            seq_reg[hidx]    <= nseq;
            ack_reg[hidx]    <= nack;
        end
    end

    assign strobe   = strobe_reg;
    assign out_item = out_reg;

    a_strobe_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (start && in_item.operation == OP_WORD && in_item.last_word) |=> strobe)
        else $error("missing result after last word");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && in_item.operation == OP_WORD && in_item.last_word) |=> !strobe)
        else $error("result without last word");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && out_item.status != STAT_OK) |-> (out_item.send_ack == 1'b0
        && out_item.reply_seq == 32'd0 && out_item.ack_mismatch == 1'b0))
        else $error("failed item carries data");
endmodule
`default_nettype wire

@@ tb/tb_segment_checker.sv @@
// Checker that predicts and compares the results of the TCP segment receive checker.
module tb_segment_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  tsrc_pkg::in_item_t  in_item,
    input  logic                strobe,
    input  tsrc_pkg::out_item_t out_item,
    output int                  fail_count,
    output int                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import tsrc_pkg::*;

    logic        conn_valid [Entries];
    logic [31:0] conn_raddr [Entries];
    logic [31:0] conn_laddr [Entries];
    logic [31:0] conn_ports [Entries];
    logic [2:0]  conn_state [Entries];
    logic [31:0] conn_seq   [Entries];
    logic [31:0] conn_ack   [Entries];
    logic [31:0] seg_sum;
    logic [15:0] seg_words;
    logic [63:0] seg_hdr0;
    logic [63:0] seg_hdr1;
    out_item_t   expected_results [$];

    assign pending_count = expected_results.size();

    function automatic logic [31:0] fold_sum(input logic [31:0] s);
        s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        return s;
    endfunction

    task automatic predict_item(input in_item_t it);
        logic [15:0] w;
        logic        odd;
        logic [15:0] len;
        logic [31:0] sum;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] sseq;
        logic [31:0] sack;
        logic [7:0]  flags;
        int          hit;
        out_item_t   r;
        if (it.operation != OP_WORD) begin
            if (it.operation == OP_OPEN) begin
                conn_valid[it.entry_index] = 1'b1;
                conn_raddr[it.entry_index] = it.remote_addr;
                conn_laddr[it.entry_index] = it.local_addr;
                conn_ports[it.entry_index] = {it.local_port, it.remote_port};
                conn_state[it.entry_index] = ST_SYN_SENT;
                conn_seq[it.entry_index] = it.seq_value;
                conn_ack[it.entry_index] = it.ack_value;
            end
            else if (it.operation == OP_FINWAIT) begin
                if (conn_valid[it.entry_index])
                    conn_state[it.entry_index] = ST_FIN_WAIT_1;
            end
            else
                conn_valid[it.entry_index] = 1'b0;
            return;
        end
        odd = it.last_word && it.last_byte_count == 2'd1;
        w = odd ? {it.data_word[15:8], 8'h00} : it.data_word;
        case (seg_words)
            16'd0: seg_hdr0[63:48] = w;
            16'd1: seg_hdr0[47:32] = w;
            16'd2: seg_hdr0[31:16] = w;
            16'd3: seg_hdr0[15:0] = w;
            16'd4: seg_hdr1[63:48] = w;
            16'd5: seg_hdr1[47:32] = w;
            16'd6: seg_hdr1[7:0] = w[7:0];
            default: ;
        endcase
        seg_sum = fold_sum(seg_sum + {16'd0, w});
        if (seg_words != 16'hffff)
            seg_words++;
        if (!it.last_word)
            return;
        len = 16'(2 * seg_words - (odd ? 1 : 0));
        sum = seg_sum + it.remote_addr[31:16] + it.remote_addr[15:0]
            + it.local_addr[31:16] + it.local_addr[15:0] + 32'd6 + len;
        sum = fold_sum(sum);
        sport = seg_hdr0[63:48];
        dport = seg_hdr0[47:32];
        sseq = seg_hdr0[31:0];
        sack = seg_hdr1[63:32];
        flags = seg_hdr1[7:0];
        seg_sum = '0;
        seg_words = '0;
        seg_hdr0 = '0;
        seg_hdr1 = '0;
        r = '0;
        hit = -1;
        if (sum != 32'h0000ffff)
            r.status = STAT_BADCS;
        else begin
            for (int i = Entries - 1; i >= 0; i--)
                if (conn_valid[i] && conn_raddr[i] == it.remote_addr
                    && conn_laddr[i] == it.local_addr && conn_ports[i] == {dport, sport})
                    hit = i;
            if (hit < 0)
                r.status = STAT_NOCON;
            else begin
                r.status = STAT_OK;
                r.ack_mismatch = sack != conn_seq[hit] + 32'd1;
                if (conn_state[hit] == ST_SYN_SENT && (flags & FLAG_ACK) != 0
                    && (flags & FLAG_SYN) != 0) begin
                    conn_ack[hit] = sseq + 32'd1;
                    conn_seq[hit] = sack;
                    conn_state[hit] = ST_ESTABLISHED;
                    r.send_ack = 1'b1;
                end
                else if (conn_state[hit] == ST_FIN_WAIT_1 && (flags & FLAG_ACK) != 0)
                    conn_state[hit] = ST_FIN_WAIT_2;
                else if (conn_state[hit] == ST_FIN_WAIT_2 && (flags & FLAG_FIN) != 0) begin
                    conn_ack[hit] = sseq + 32'd1;
                    conn_seq[hit] = sack;
                    conn_state[hit] = ST_CLOSED;
                    r.send_ack = 1'b1;
                end
                r.reply_seq = conn_seq[hit];
                r.reply_ack = conn_ack[hit];
                r.matched_entry = 3'(hit);
                r.new_state = conn_state[hit];
            end
        end
        expected_results.push_back(r);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("Unexpected result %p", got);
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status || got.ack_mismatch !== want.ack_mismatch
            || got.send_ack !== want.send_ack || got.reply_seq !== want.reply_seq
            || got.reply_ack !== want.reply_ack || got.matched_entry !== want.matched_entry
            || got.new_state !== want.new_state) begin
            fail_count++;
            if (fail_count <= 10)
                $display("Mismatch: expected %p, actual %p", want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fail_count <= 0;
            seg_sum = '0;
            seg_words = '0;
            seg_hdr0 = '0;
            seg_hdr1 = '0;
            for (int i = 0; i < Entries; i++)
                conn_valid[i] = 1'b0;
        end
        else begin
            if (strobe)
                check_result(out_item);
            if (start && !busy)
                predict_item(in_item);
        end
    end
endmodule

@@ tb/tb_top.sv @@
// Top of the testbench: clock, reset, segment and table stimulus, and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tsrc_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  in_item;
    logic      strobe;
    out_item_t out_item;
    int        fail_count;
    int        pending_count;
    int        idle_cycles;
    bit        quiet_run;

    logic [31:0] tb_raddr [Entries];
    logic [31:0] tb_laddr [Entries];
    logic [15:0] tb_lport [Entries];
    logic [15:0] tb_rport [Entries];
    logic [31:0] tb_seq [Entries];

    tcp_segment_receive_checker_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_item(in_item), .strobe(strobe), .out_item(out_item)
    );

    tb_segment_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .strobe(strobe), .out_item(out_item), .fail_count(fail_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic in_item_t random_item();
        logic [191:0] r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return r[$bits(in_item_t)-1:0];
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        if (!quiet_run && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic table_op(input logic [1:0] op, input int idx);
        in_item_t it;
        it = random_item();
        it.operation = op;
        it.entry_index = 3'(idx);
        if (op == OP_OPEN) begin
            tb_raddr[idx] = it.remote_addr;
            tb_laddr[idx] = it.local_addr;
            tb_lport[idx] = it.local_port;
            tb_rport[idx] = it.remote_port;
            tb_seq[idx] = it.seq_value;
        end
        send_item(it);
    endtask

    // Sends a segment; good checksum unless corrupt or random_words, odd tail when odd_len.
    task automatic send_segment(input int idx, input logic [7:0] flags, input int nwords,
                                input bit odd_len, input bit corrupt, input bit right_ack,
                                input bit random_words);
        logic [15:0] w [$];
        logic [31:0] s;
        logic [31:0] seqv;
        logic [31:0] ackv;
        logic [15:0] len;
        in_item_t    it;
        seqv = $urandom;
        ackv = right_ack ? tb_seq[idx] + 32'd1 : $urandom;
        if (random_words) begin
            for (int i = 0; i < nwords; i++)
                w.push_back(16'($urandom));
        end
        else begin
            w = {tb_rport[idx], tb_lport[idx], seqv[31:16], seqv[15:0],
                 ackv[31:16], ackv[15:0], {8'h50, flags}, 16'($urandom), 16'h0000};
            for (int i = 9; i < nwords; i++)
                w.push_back(16'($urandom));
        end
        if (odd_len)
            w[w.size() - 1][7:0] = 8'h00;
        if (!random_words) begin
            w[8] = 16'h0000;
            len = 16'(2 * w.size() - (odd_len ? 1 : 0));
            s = tb_raddr[idx][31:16] + tb_raddr[idx][15:0] + tb_laddr[idx][31:16]
                + tb_laddr[idx][15:0] + 32'd6 + len;
            foreach (w[i])
                s = s + w[i];
            s = {16'd0, s[15:0]} + s[31:16];
            s = {16'd0, s[15:0]} + s[31:16];
            w[8] = ~s[15:0];
            if (corrupt)
                w[8] = w[8] ^ 16'(1 << $urandom_range(0, 15));
        end
        foreach (w[i]) begin
            it = random_item();
            it.operation = OP_WORD;
            it.remote_addr = tb_raddr[idx];
            it.local_addr = tb_laddr[idx];
            it.data_word = w[i];
            if (odd_len && i == w.size() - 1)
                it.data_word[7:0] = 8'($urandom);
            it.last_word = i == w.size() - 1;
            it.last_byte_count = it.last_word ? (odd_len ? 2'd1 : 2'd2) : 2'($urandom);
            send_item(it);
            if (!it.last_word && $urandom_range(0, 30) == 0)
                table_op(OP_FINWAIT, $urandom_range(0, Entries - 1));
        end
    endtask

    task automatic random_step();
        int idx;
        int pick;
        logic [7:0] fl;
        idx = $urandom_range(0, Entries - 1);
        pick = $urandom_range(0, 19);
        fl = $urandom_range(0, 3) == 0 ? 8'($urandom)
            : (8'($urandom) & ~(FLAG_ACK | FLAG_SYN | FLAG_FIN))
              | ($urandom_range(0, 1) ? FLAG_ACK : 8'h0)
              | ($urandom_range(0, 1) ? FLAG_SYN : 8'h0)
              | ($urandom_range(0, 1) ? FLAG_FIN : 8'h0);
        if (pick < 2)
            table_op(OP_OPEN, idx);
        else if (pick < 4)
            table_op(OP_FINWAIT, idx);
        else if (pick < 5)
            table_op(OP_RELEASE, idx);
        else if (pick < 6)
            send_segment(idx, fl, $urandom_range(1, 12), $urandom_range(0, 1), 0, 0, 1);
        else
            send_segment(idx, fl, $urandom_range(9, 14), $urandom_range(0, 1),
                         $urandom_range(0, 9) == 0, $urandom_range(0, 3) != 0, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        quiet_run = 1'b0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < Entries; i++)
            table_op(OP_OPEN, i);
        send_segment(0, FLAG_ACK | FLAG_SYN, 9, 0, 0, 1, 0);
        send_segment(0, FLAG_ACK | FLAG_SYN, 9, 0, 0, 0, 0);
        send_segment(1, 8'hff, 10, 1, 0, 1, 0);
        send_segment(2, FLAG_ACK, 9, 0, 1, 1, 0);
        table_op(OP_FINWAIT, 0);
        send_segment(0, FLAG_ACK, 9, 0, 0, 1, 0);
        send_segment(0, FLAG_FIN, 10, 1, 0, 1, 0);
        table_op(OP_RELEASE, 3);
        send_segment(3, FLAG_ACK | FLAG_SYN, 9, 0, 0, 1, 0);
        table_op(OP_FINWAIT, 3);
        send_segment(4, 8'h00, 1, 1, 0, 0, 1);
        send_segment(5, 8'h00, 3, 0, 0, 0, 1);
        for (int n = 0; n < 125; n++) begin
            if (n == 50) begin
                start <= 1'b0;
                @(posedge clk);
                while (pending_count != 0)
                    @(posedge clk);
            end
            if (n == 100)
                quiet_run = 1'b1;
            random_step();
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/tsrc_pkg.sv
rtl/tcp_segment_receive_checker_top.sv
tb/tb_segment_checker.sv
tb/tb_top.sv
